### rtl/olins_pkg.sv
// ----------------------------------------------------------------------------
// olins_pkg
// Shared types and constants for the ordered list insert-at-position unit.
// ----------------------------------------------------------------------------
package olins_pkg;

  localparam int CAPACITY = 16;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;

  typedef enum logic [1:0] {
    STATUS_INSERTED = 2'd0,
    STATUS_BADPOS   = 2'd1,
    STATUS_FULL     = 2'd2,
    STATUS_REPORT   = 2'd3
  } status_t;

  typedef enum logic {
    OP_INSERT   = 1'b0,
    OP_TRAVERSE = 1'b1
  } opcode_t;

  typedef struct packed {
    logic               opcode;
    logic [4:0]         position;
    logic signed [31:0] value;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] element;
    logic [3:0]         element_index;
    logic               is_empty;
    logic [4:0]         list_length;
    logic               last;
  } out_beat_t;

endpackage

### rtl/olins_ram.sv
// ----------------------------------------------------------------------------
// olins_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module olins_ram #(
  parameter int DEPTH  = 16,
  parameter int WIDTH  = 32,
  parameter int AW     = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds its value until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/ordered_list_insert_at_position_unit.sv
// ----------------------------------------------------------------------------
// ordered_list_insert_at_position_unit
// Bounded ordered list of signed 32-bit elements with insert and traverse.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid, in_stall, in_data) carries one command
// beat: an insert of a value at a 1-based position, or a traverse. The result
// channel (out_valid, out_stall, out_data) returns one beat per insert
// (inserted, bad position or list full) and, per traverse, one beat per stored
// element in order with the last flag on the final one, or a single empty
// report. The elements live in a 16-entry RAM with registered read data.
// An insert that moves elements shifts them first, one element a cycle down
// from the tail, reading entry j-1 and writing entry j in the next cycle,
// after which the new value is written. An insert at the end moves nothing.
// A rejected insert or an empty traverse goes from acceptance straight to
// its single result beat. A traverse streams one beat a cycle while the
// receiver does not stall; the RAM ports set the pace. One command is worked
// on at a time; the next is taken once the previous one has handed its last
// beat to the output register. Reset empties the list (count zero, RAM
// contents left as they are) and drops any pending result. When the
// receiver stalls, the output register holds its beat and the unit waits.
// ----------------------------------------------------------------------------
module ordered_list_insert_at_position_unit
  import olins_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_PUT,
    S_RESP,
    S_TRAV
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [4:0]         pos_r, pos_nxt;
  logic [DATA_W-1:0]  val_r, val_nxt;
  status_t            resp_status_r, resp_status_nxt;
  logic               resp_empty_r, resp_empty_nxt;
  // Shift index (insert) or next read index (traverse).
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic               wr_pend_r, wr_pend_nxt;
  logic [ADDR_W-1:0]  wr_addr_r, wr_addr_nxt;
  logic               rd_pend_r, rd_pend_nxt;
  logic [ADDR_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_beat_t          out_data_r, out_data_nxt;

  logic               ram_wr_en;
  logic [ADDR_W-1:0]  ram_wr_addr;
  logic [DATA_W-1:0]  ram_wr_data;
  logic               ram_rd_en;
  logic [ADDR_W-1:0]  ram_rd_addr;
  logic [DATA_W-1:0]  ram_rd_data;

  logic               in_fire;
  logic               out_free;
  logic               consume;
  logic [CNT_W:0]     count_plus1;
  logic               pos_bad;
  logic [CNT_W-1:0]   pos_ext;

  olins_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;

  assign count_plus1 = {1'b0, count_r} + (CNT_W + 1)'(1);
  assign pos_bad     = (in_data.position == 5'd0) ||
                       ({{(CNT_W + 1 - 5){1'b0}}, in_data.position} > count_plus1);
  assign pos_ext     = CNT_W'(pos_r);

  // A traverse beat moves from RAM read data into the output register.
  assign consume = (state_r == S_TRAV) && rd_pend_r && out_free;

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    pos_nxt         = pos_r;
    val_nxt         = val_r;
    resp_status_nxt = resp_status_r;
    resp_empty_nxt  = resp_empty_r;
    idx_nxt         = idx_r;
    wr_pend_nxt     = 1'b0;
    wr_addr_nxt     = wr_addr_r;
    rd_pend_nxt     = rd_pend_r;
    rd_idx_nxt      = rd_idx_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_data_nxt    = out_data_r;

    ram_wr_en   = 1'b0;
    ram_wr_addr = wr_addr_r;
    ram_wr_data = ram_rd_data;
    ram_rd_en   = 1'b0;
    ram_rd_addr = '0;

    // Shifted element read last cycle goes to its new slot.
    if (wr_pend_r) begin
      ram_wr_en = 1'b1;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          pos_nxt        = in_data.position;
          val_nxt        = in_data.value;
          resp_empty_nxt = 1'b0;
          idx_nxt        = count_r;
          if (in_data.opcode == OP_TRAVERSE) begin
            if (count_r == '0) begin
              resp_status_nxt = STATUS_REPORT;
              resp_empty_nxt  = 1'b1;
              state_nxt       = S_RESP;
            end else begin
              idx_nxt     = '0;
              rd_pend_nxt = 1'b0;
              state_nxt   = S_TRAV;
            end
          end else if (pos_bad) begin
            resp_status_nxt = STATUS_BADPOS;
            state_nxt       = S_RESP;
          end else if (count_r == CNT_W'(CAPACITY)) begin
            resp_status_nxt = STATUS_FULL;
            state_nxt       = S_RESP;
          end else begin
            resp_status_nxt = STATUS_INSERTED;
            if ({{(CNT_W + 1 - 5){1'b0}}, in_data.position} == count_plus1) begin
              state_nxt = S_PUT;
            end else begin
              state_nxt = S_SHIFT;
            end
          end
        end
      end

      S_SHIFT: begin
        // Read entry idx-1 now, write it to entry idx next cycle.
        ram_rd_en   = 1'b1;
        ram_rd_addr = ADDR_W'(idx_r - CNT_W'(1));
        wr_pend_nxt = 1'b1;
        wr_addr_nxt = ADDR_W'(idx_r);
        if (idx_r == pos_ext) begin
          state_nxt = S_PUT;
        end else begin
          idx_nxt = idx_r - CNT_W'(1);
        end
      end

      S_PUT: begin
        // The last shifted write drains first; then the new value goes in.
        if (!wr_pend_r) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = ADDR_W'(pos_r - 5'd1);
          ram_wr_data = val_r;
          count_nxt   = count_r + CNT_W'(1);
          state_nxt   = S_RESP;
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.status        = resp_status_r;
          out_data_nxt.element       = '0;
          out_data_nxt.element_index = '0;
          out_data_nxt.is_empty      = resp_empty_r;
          out_data_nxt.list_length   = 5'(count_r);
          out_data_nxt.last          = 1'b1;
          state_nxt                  = S_IDLE;
        end
      end

      S_TRAV: begin
        if (consume) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.status        = STATUS_REPORT;
          out_data_nxt.element       = signed'(ram_rd_data);
          out_data_nxt.element_index = 4'(rd_idx_r);
          out_data_nxt.is_empty      = 1'b0;
          out_data_nxt.list_length   = 5'(count_r);
          out_data_nxt.last          = (CNT_W'(rd_idx_r) + CNT_W'(1) == count_r);
          rd_pend_nxt                = 1'b0;
        end
        // Issue the next read only when the read data register is free.
        if ((idx_r < count_r) && (!rd_pend_r || consume)) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = ADDR_W'(idx_r);
          rd_pend_nxt = 1'b1;
          rd_idx_nxt  = ADDR_W'(idx_r);
          idx_nxt     = idx_r + CNT_W'(1);
        end else if ((idx_r == count_r) && (!rd_pend_r || consume)) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      wr_pend_r   <= 1'b0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      wr_pend_r   <= wr_pend_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pos_r         <= pos_nxt;
    val_r         <= val_nxt;
    resp_status_r <= resp_status_nxt;
    resp_empty_r  <= resp_empty_nxt;
    idx_r         <= idx_nxt;
    wr_addr_r     <= wr_addr_nxt;
    rd_idx_r      <= rd_idx_nxt;
    out_data_r    <= out_data_nxt;
  end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the ordered list insert-at-position unit.
// Commands go in as beats on the input channel. A predictor keeps its own copy
// of the list and works out the result beats for each accepted command. A
// monitor compares every accepted result beat, field by field, with the
// oldest prediction. Directed cases cover the empty list, inserts at the
// front, middle and end, rejected positions and the full list. Random traffic
// grows the list slowly so that traverses of many lengths are seen, under
// several idle and stall patterns and one long output hold-off.
// ----------------------------------------------------------------------------
module tb;
  import olins_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_data;

  // Predictor state: a private copy of the list and its length.
  logic signed [31:0] list_mem [CAPACITY];
  int                 list_count;

  // Result beats predicted but not yet seen on the output, oldest first.
  out_beat_t awaited_beats[$];

  int mismatches = 0;

  // Traffic shaping, changed by the tests between phases.
  int   send_idle_pct;
  int   stall_pct;
  int   hold_len;
  event hold_start;
  bit   hold_active = 1'b0;

  ordered_list_insert_at_position_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The whole run may take at most this long; a hang ends here.
  initial begin
    #8_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Works out the result beats of one accepted command and updates the
  // private list. An insert always answers with a single beat. A traverse
  // answers with one beat per stored element, or a lone empty report.
  function automatic void apply_command(input in_beat_t cmd);
    out_beat_t res;
    res = '0;
    if (cmd.opcode == OP_INSERT) begin
      res.last = 1'b1;
      // The position check wins over the full check.
      if (cmd.position == 0 || int'(cmd.position) > list_count + 1) begin
        res.status = STATUS_BADPOS;
      end else if (list_count == CAPACITY) begin
        res.status = STATUS_FULL;
      end else begin
        for (int j = list_count; j >= int'(cmd.position); j--) begin
          list_mem[j] = list_mem[j - 1];
        end
        list_mem[cmd.position - 1] = cmd.value;
        list_count++;
        res.status = STATUS_INSERTED;
      end
      res.list_length = 5'(list_count);
      awaited_beats.push_back(res);
    end else if (list_count == 0) begin
      res.status      = STATUS_REPORT;
      res.is_empty    = 1'b1;
      res.last        = 1'b1;
      awaited_beats.push_back(res);
    end else begin
      for (int j = 0; j < list_count; j++) begin
        res.status        = STATUS_REPORT;
        res.element       = list_mem[j];
        res.element_index = 4'(j);
        res.list_length   = 5'(list_count);
        res.last          = (j == list_count - 1);
        awaited_beats.push_back(res);
      end
    end
  endfunction

  function automatic void note_mismatch(input string what, input out_beat_t want,
                                        input out_beat_t got, input bit have_want);
    mismatches++;
    if (mismatches <= 10) begin
      $display("Mismatch (%s) at %0t ns", what, $time);
      if (have_want) begin
        $display("  expected status=%0d element=%0d index=%0d empty=%0b length=%0d last=%0b",
                 want.status, want.element, want.element_index, want.is_empty,
                 want.list_length, want.last);
      end
      $display("  actual   status=%0d element=%0d index=%0d empty=%0b length=%0d last=%0b",
               got.status, got.element, got.element_index, got.is_empty,
               got.list_length, got.last);
    end
  endfunction

  // Result monitor. Values are taken at the rising edge, before the block's
  // registers move, and out_stall only ever changes at the falling edge.
  always @(posedge clk) begin : result_monitor
    out_beat_t want;
    string     bad;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_beats.size() == 0) begin
        note_mismatch("result beat with nothing expected", '0, out_data, 1'b0);
      end else begin
        want = awaited_beats.pop_front();
        bad  = "";
        if (out_data.status        !== want.status)        bad = {bad, " status"};
        if (out_data.element       !== want.element)       bad = {bad, " element"};
        if (out_data.element_index !== want.element_index) bad = {bad, " element_index"};
        if (out_data.is_empty      !== want.is_empty)      bad = {bad, " is_empty"};
        if (out_data.list_length   !== want.list_length)   bad = {bad, " list_length"};
        if (out_data.last          !== want.last)          bad = {bad, " last"};
        if (bad != "") note_mismatch({"field", bad}, want, out_data, 1'b1);
      end
    end
  end

  // Hold-off counter. A request from a test keeps the receiver stalled for
  // the requested number of cycles.
  always begin : hold_counter
    @(hold_start);
    hold_active = 1'b1;
    repeat (hold_len) @(posedge clk);
    hold_active = 1'b0;
  end

  // Receiver. During a hold-off it stalls every cycle; otherwise it stalls
  // at random.
  always @(negedge clk) begin
    if (hold_active) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Offers one command beat and holds it until the block takes it. While the
  // sender idles the payload wanders, which the block has to ignore.
  task automatic send_command(input in_beat_t cmd);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_data  <= {1'($urandom), 5'($urandom), $urandom};
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= cmd;
    do @(posedge clk); while (in_stall);
    apply_command(cmd);
  endtask

  // Stops offering and waits until every predicted beat has come out.
  task automatic wait_for_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_beats.size() != 0) @(posedge clk);
  endtask

  function automatic in_beat_t make_command(input logic op, input int pos,
                                            input logic signed [31:0] val);
    in_beat_t cmd;
    cmd.opcode   = op;
    cmd.position = 5'(pos);
    cmd.value    = val;
    return cmd;
  endfunction

  // Random command. Valid inserts are only allowed while the list is shorter
  // than grow_cap, so the list fills gradually over the random part.
  function automatic in_beat_t make_random_command(input int grow_cap);
    in_beat_t    cmd;
    int unsigned pick;
    int unsigned vpick;
    pick  = $urandom_range(99);
    vpick = $urandom_range(99);
    cmd.value    = $urandom;
    cmd.position = 5'($urandom_range(31));
    if (vpick < 3)      cmd.value = 32'sh7fff_ffff;
    else if (vpick < 6) cmd.value = 32'sh8000_0000;
    else if (vpick < 8) cmd.value = '0;
    if (pick < 40) begin
      cmd.opcode = OP_TRAVERSE;
    end else begin
      cmd.opcode = OP_INSERT;
      if (pick < 55 && list_count < grow_cap) begin
        cmd.position = 5'($urandom_range(list_count + 1, 1));
      end else if (pick < 70 && list_count == CAPACITY) begin
        cmd.position = 5'($urandom_range(CAPACITY + 1, 1));
      end else if (pick[0]) begin
        cmd.position = 0;
      end else begin
        cmd.position = 5'($urandom_range(31, list_count + 2));
      end
    end
    return cmd;
  endfunction

  // An empty list: traverse gives the empty report, and every insert
  // position other than one is rejected.
  task automatic test_empty_list();
    send_command(make_command(OP_TRAVERSE, 0, 0));
    send_command(make_command(OP_INSERT, 0, 32'sh1234_5678));
    send_command(make_command(OP_INSERT, 2, -32'sd5));
    send_command(make_command(OP_INSERT, 31, 32'sh7fff_ffff));
  endtask

  // Inserts at the end, the front and the middle, with extreme values, then
  // a traverse and a position just past the end.
  task automatic test_insert_positions();
    send_command(make_command(OP_INSERT, 1, 32'sh8000_0000));
    send_command(make_command(OP_INSERT, 2, 32'sh7fff_ffff));
    send_command(make_command(OP_INSERT, 1, -32'sd1));
    send_command(make_command(OP_INSERT, 2, 32'sd0));
    send_command(make_command(OP_INSERT, 5, 32'sh5555_aaaa));
    send_command(make_command(OP_TRAVERSE, 31, 32'shffff_ffff));
    send_command(make_command(OP_INSERT, 7, 32'sd42));
    wait_for_drain();
  endtask

  // One phase of random traffic with the given idle and stall rates.
  task automatic test_random_traffic(input int n_items, input int send_pct,
                                     input int recv_pct, inout int done_items);
    int grow_cap;
    send_idle_pct = send_pct;
    stall_pct     = recv_pct;
    for (int i = 0; i < n_items; i++) begin
      grow_cap = 5 + (done_items * 11) / 230;
      if (grow_cap > CAPACITY) grow_cap = CAPACITY;
      send_command(make_random_command(grow_cap));
      done_items++;
    end
    // Sender pauses here until every result of the phase is out.
    wait_for_drain();
  endtask

  // The receiver holds off for a long stretch while commands keep coming,
  // so the output register fills and the block stalls its input.
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_len      = 150;
    -> hold_start;
    for (int i = 0; i < 8; i++) begin
      if (i[0]) send_command(make_random_command(list_count));
      else      send_command(make_command(OP_TRAVERSE, $urandom_range(31), $urandom));
    end
    wait_for_drain();
  endtask

  // Fills the list, then hits it with positions that are valid (full) and
  // invalid (bad position wins), and traverses all sixteen elements.
  task automatic test_full_list();
    send_idle_pct = 20;
    stall_pct     = 20;
    while (list_count < CAPACITY) begin
      send_command(make_command(OP_INSERT, $urandom_range(list_count + 1, 1), $urandom));
    end
    send_command(make_command(OP_INSERT, 1, 32'sd7));
    send_command(make_command(OP_INSERT, CAPACITY + 1, 32'sd8));
    send_command(make_command(OP_INSERT, 0, 32'sd9));
    send_command(make_command(OP_INSERT, CAPACITY + 2, 32'sd10));
    send_command(make_command(OP_INSERT, 31, -32'sd11));
    send_command(make_command(OP_TRAVERSE, 0, 0));
    wait_for_drain();
  endtask

  initial begin : main_sequence
    int random_done;
    random_done   = 0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    list_count    = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_len      = 0;
    for (int i = 0; i < CAPACITY; i++) list_mem[i] = '0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_list();
    test_insert_positions();
    test_random_traffic(72, 0, 0, random_done);
    test_random_traffic(72, 66, 0, random_done);
    test_backpressure();
    test_random_traffic(72, 0, 66, random_done);
    test_random_traffic(72, 20, 20, random_done);
    test_full_list();

    // Give any stray extra beat time to show up before the verdict.
    repeat (40) @(posedge clk);
    if (mismatches == 0 && awaited_beats.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
